FILE: src/cfm_pkg.sv
`default_nettype none
package cfm_pkg;

	// parameter defaults
	localparam int NUM_CHANNELS_DEF   = 3;
	localparam int TIMESTAMP_BITS_DEF = 16;

	// field widths
	localparam int CMD_W      = 2;
	localparam int CHAN_W     = 2;
	localparam int CAP_W      = 16;
	localparam int ERR_W      = 16;
	localparam int TMO_W      = 8;
	localparam int PERIOD_W   = 20;
	localparam int PULSE_W    = 19;
	localparam int FREQ_W     = 25;
	localparam int IN_TDATA_W = 24;
	localparam int OUT_TDATA_W = 88;

	// counter limits
	localparam logic [ERR_W-1:0] ERR_MAX     = '1;
	localparam logic [TMO_W-1:0] TMO_MAX     = '1;
	localparam logic [TMO_W-1:0] TIMEOUT_RST = 8'd10;

	// Q8 Hz numerator: 1e6 us/s * 256
	localparam int QNUM_W = 28;
	localparam logic [QNUM_W-1:0] HZ_Q8_NUM = 28'd256000000;
	localparam int DCNT_W = $clog2(QNUM_W);

	typedef enum logic [CMD_W-1:0] {
		CMD_CAPTURE = 2'd0,
		CMD_TICK    = 2'd1,
		CMD_CLEAR   = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CAP  = 5'b00010,
		ST_SCAN = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

endpackage
`default_nettype wire

FILE: src/capture_frequency_meter.sv
`default_nettype none
// Capture frequency meter.
// Input channel (s_*): one item per command. s_tuser carries the command
// (capture event, 100 ms tick, clear all). A capture item carries channel,
// capture_valid, a 16-bit timestamp in 10 us units and the overcapture bit.
// Output channel (m_*): one item per completed period: channel number,
// error count, period and half period in us, frequency in Q8 Hz.
// Config: cfg_we writes cfg_wdata into timeout_ticks (reset 10); write only
// while idle.
// Timing: a capture that completes a period goes through the update state,
// the shared restoring divider (one quotient bit per cycle) and the load of
// the output register; s_tready returns in the same cycle as the result
// shows. A first capture or an error-only capture passes only the update
// state. A tick walks the channels one per cycle. A clear is done in the
// idle state, ready stays high.
// Stall: the output register holds its result while m_tready is low; new
// items are still taken until a following result reaches ST_DONE, where it
// waits with s_tready low until the register frees up.
// Reset: all channel state cleared, timeout_ticks back to 10, no result.
module capture_frequency_meter #(
	parameter int NUM_CHANNELS   = cfm_pkg::NUM_CHANNELS_DEF,
	parameter int TIMESTAMP_BITS = cfm_pkg::TIMESTAMP_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output      logic                           s_tready,
	// [1:0] channel, [2] capture_valid, [18:3] capture_value, [19] overcapture
	input  wire logic [cfm_pkg::IN_TDATA_W-1:0] s_tdata,
	// [1:0] command
	input  wire logic [cfm_pkg::CMD_W-1:0]      s_tuser,
	output      logic                           m_tvalid,
	input  wire logic                           m_tready,
	// [1:0] channel_number, [17:2] err_count, [37:18] period_us,
	// [56:38] pulse_width_us, [81:57] frequency_q8
	output      logic [cfm_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  wire logic                           cfg_we,
	input  wire logic [cfm_pkg::TMO_W-1:0]      cfg_wdata
);
	import cfm_pkg::*;

	localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int TB = TIMESTAMP_BITS;
	localparam int VW = (TB < CAP_W) ? TB : CAP_W;
	// period in us: ticks (up to 2^TB) times ten
	localparam int PW = TB + 5;

	state_t state_q;

	// per-channel state
	logic [TB-1:0]    first_q [NUM_CHANNELS];
	logic             have_q  [NUM_CHANNELS];
	logic [ERR_W-1:0] err_q   [NUM_CHANNELS];
	logic [TMO_W-1:0] tmo_q   [NUM_CHANNELS];
	logic             capt_q  [NUM_CHANNELS];

	logic [TMO_W-1:0] timeout_q;

	// latched capture item
	logic [CHAN_W-1:0] chan_q;
	logic              vld_q;
	logic [VW-1:0]     value_q;
	logic              ovr_q;

	logic [CW-1:0]     scan_q;

	// divider
	logic [PW-1:0]     div_q;
	logic [PW-1:0]     rem_q;
	logic [QNUM_W-1:0] quo_q;
	logic [DCNT_W-1:0] dcnt_q;

	// pending result
	logic [CHAN_W-1:0] res_ch_q;
	logic [ERR_W-1:0]  res_err_q;

	// output register
	logic                out_valid_q;
	logic [CHAN_W-1:0]   out_ch_q;
	logic [ERR_W-1:0]    out_err_q;
	logic [PERIOD_W-1:0] out_per_q;
	logic [PULSE_W-1:0]  out_pw_q;
	logic [FREQ_W-1:0]   out_freq_q;

	// decode of the incoming item
	logic       s_acc;
	cmd_t       s_cmd;
	logic       s_chan_ok;

	// channel read port and update logic
	logic [CW-1:0]    idx;
	logic [TB-1:0]    cur_first;
	logic             cur_have;
	logic [ERR_W-1:0] cur_err;
	logic [TMO_W-1:0] cur_tmo;
	logic             cur_capt;
	logic [ERR_W-1:0] err_inc;
	logic [TB-1:0]    ts_in;
	logic [TB-1:0]    ticks_raw;
	logic [TB:0]      ticks;
	logic [PW-1:0]    per;
	logic [TMO_W-1:0] tmo_inc;
	logic             tmo_hit;

	logic [PW:0]      div_shift;
	logic [PW:0]      div_diff;
	logic             div_ge;

	assign s_tready  = (state_q == ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign s_cmd     = cmd_t'(s_tuser);
	assign s_chan_ok = (32'(s_tdata[CHAN_W-1:0]) < NUM_CHANNELS);

	always_comb begin
		idx       = (state_q == ST_SCAN) ? scan_q : CW'(chan_q);
		cur_first = first_q[idx];
		cur_have  = have_q[idx];
		cur_err   = err_q[idx];
		cur_tmo   = tmo_q[idx];
		cur_capt  = capt_q[idx];

		// overcapture counts before the period is taken
		err_inc = (ovr_q && (cur_err != ERR_MAX)) ? cur_err + 1'b1 : cur_err;

		// wrap-aware difference; equal stamps mean a full wrap
		ts_in     = TB'(value_q);
		ticks_raw = ts_in - cur_first;
		ticks     = (ticks_raw == '0) ? {1'b1, {TB{1'b0}}} : {1'b0, ticks_raw};
		per       = (PW'(ticks) << 3) + (PW'(ticks) << 1);

		tmo_inc = (cur_tmo != TMO_MAX) ? cur_tmo + 1'b1 : cur_tmo;
		tmo_hit = (tmo_inc >= timeout_q);

		// one restoring step: remainder always stays below the divisor
		div_shift = {rem_q, quo_q[QNUM_W-1]};
		div_ge    = (div_shift >= {1'b0, div_q});
		div_diff  = div_shift - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			timeout_q   <= TIMEOUT_RST;
			out_valid_q <= 1'b0;
			scan_q      <= '0;
			dcnt_q      <= '0;
			chan_q      <= '0;
			vld_q       <= 1'b0;
			value_q     <= '0;
			ovr_q       <= 1'b0;
			div_q       <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			res_ch_q    <= '0;
			res_err_q   <= '0;
			out_ch_q    <= '0;
			out_err_q   <= '0;
			out_per_q   <= '0;
			out_pw_q    <= '0;
			out_freq_q  <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				first_q[i] <= '0;
				have_q[i]  <= 1'b0;
				err_q[i]   <= '0;
				tmo_q[i]   <= '0;
				capt_q[i]  <= 1'b0;
			end
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			// a result loaded in ST_DONE takes over the drained register
			if (out_valid_q && m_tready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						chan_q  <= s_tdata[CHAN_W-1:0];
						vld_q   <= s_tdata[CHAN_W];
						value_q <= s_tdata[CHAN_W+1 +: VW];
						ovr_q   <= s_tdata[CHAN_W+1+CAP_W];
						case (s_cmd)
							CMD_CAPTURE: begin
								if (s_chan_ok) begin
									state_q <= ST_CAP;
								end
							end
							CMD_TICK: begin
								scan_q  <= '0;
								state_q <= ST_SCAN;
							end
							CMD_CLEAR: begin
								for (int i = 0; i < NUM_CHANNELS; i++) begin
									first_q[i] <= '0;
									have_q[i]  <= 1'b0;
									err_q[i]   <= '0;
									tmo_q[i]   <= '0;
									capt_q[i]  <= 1'b0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_CAP: begin
					err_q[idx] <= err_inc;
					if (vld_q) begin
						if (!cur_have) begin
							first_q[idx] <= ts_in;
							have_q[idx]  <= 1'b1;
							state_q      <= ST_IDLE;
						end else begin
							tmo_q[idx]   <= '0;
							first_q[idx] <= '0;
							have_q[idx]  <= 1'b0;
							capt_q[idx]  <= 1'b1;
							res_ch_q     <= chan_q + 1'b1;
							res_err_q    <= err_inc;
							div_q        <= per;
							rem_q        <= '0;
							quo_q        <= HZ_Q8_NUM;
							dcnt_q       <= '0;
							state_q      <= ST_DIV;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (cur_capt) begin
						capt_q[idx] <= 1'b0;
					end else if (tmo_hit) begin
						first_q[idx] <= '0;
						have_q[idx]  <= 1'b0;
						err_q[idx]   <= '0;
						tmo_q[idx]   <= '0;
						capt_q[idx]  <= 1'b0;
					end else begin
						tmo_q[idx] <= tmo_inc;
					end
					scan_q <= scan_q + 1'b1;
					if (scan_q == CW'(NUM_CHANNELS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					rem_q  <= div_ge ? div_diff[PW-1:0] : div_shift[PW-1:0];
					quo_q  <= {quo_q[QNUM_W-2:0], div_ge};
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == DCNT_W'(QNUM_W - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_ch_q    <= res_ch_q;
						out_err_q   <= res_err_q;
						out_per_q   <= PERIOD_W'(div_q);
						out_pw_q    <= PULSE_W'(div_q >> 1);
						out_freq_q  <= quo_q[FREQ_W-1:0];
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W - CHAN_W - ERR_W - PERIOD_W - PULSE_W - FREQ_W){1'b0}},
		out_freq_q, out_pw_q, out_per_q, out_err_q, out_ch_q};

endmodule
`default_nettype wire

FILE: src/cfm_checker.sv
`default_nettype none
module cfm_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_tvalid,
	input wire logic                            s_tready,
	input wire logic [cfm_pkg::CMD_W-1:0]       s_tuser,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [cfm_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import cfm_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// half period is the period shifted by one
	a_pulse_half: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[56:38] == m_tdata[37:19]))
		else $error("pulse width is not half the period");

	// a tick walks the channels, so the input side blocks
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == CMD_TICK) |=> !s_tready)
		else $error("ready during tick scan");

	// a clear is done on the spot
	a_clear_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == CMD_CLEAR) |=> s_tready)
		else $error("not ready after clear");

endmodule

bind capture_frequency_meter cfm_checker u_cfm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

FILE: tb/capture_frequency_meter_tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the capture frequency meter. Items go in on the
// s_* stream; each one is run through a local model of the per-channel state
// when it is accepted. Completed periods queue an expected reading, and every
// reading taken off m_* is compared field by field against the oldest one.
module capture_frequency_meter_tb;
	import cfm_pkg::*;

	localparam int NCH           = NUM_CHANNELS_DEF;
	// longest non-result work is a tick walk
	localparam int SETTLE_CYCLES = 40;

	typedef struct {
		cmd_t              cmd;
		logic [CHAN_W-1:0] chan;
		logic              cap_valid;
		logic [CAP_W-1:0]  cap_value;
		logic              over;
	} meter_item_t;

	typedef struct {
		logic [1:0]          chan_num;
		logic [ERR_W-1:0]    err;
		logic [PERIOD_W-1:0] period;
		logic [PULSE_W-1:0]  pulse;
		logic [FREQ_W-1:0]   freq;
	} reading_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	// [1:0] channel, [2] capture_valid, [18:3] capture_value, [19] overcapture
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	// [1:0] command
	logic [CMD_W-1:0]       s_tuser   = CMD_CAPTURE;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	// [1:0] channel_number, [17:2] err_count, [37:18] period_us,
	// [56:38] pulse_width_us, [81:57] frequency_q8
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we    = 1'b0;
	logic [TMO_W-1:0]       cfg_wdata = '0;

	// Model of the channel state, updated as each item is accepted
	logic [CAP_W-1:0] first_ts   [NCH];
	bit               armed      [NCH];
	logic [ERR_W-1:0] miss_count [NCH];
	logic [TMO_W-1:0] idle_count [NCH];
	bit               fresh      [NCH];
	logic [TMO_W-1:0] timeout_limit;

	reading_t expected_readings[$];
	int       mismatch_count = 0;

	// Traffic shaping knobs, set per test
	bit gaps_on    = 1'b0;
	bit stalls_on  = 1'b0;
	int burst_left = 0;
	int stall_left = 0;

	capture_frequency_meter u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Run ends here if the block hangs
	initial begin
		#30_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic void wipe_channel(int c);
		first_ts[c]   = '0;
		armed[c]      = 1'b0;
		miss_count[c] = '0;
		idle_count[c] = '0;
		fresh[c]      = 1'b0;
	endfunction

	// Advance the channel model by one item; queue a reading if a period closes
	function automatic void predict_reading(meter_item_t it);
		int          c;
		logic [16:0] span;
		int unsigned per;
		reading_t    r;
		case (it.cmd)
			CMD_TICK: begin
				for (int k = 0; k < NCH; k++) begin
					if (fresh[k]) begin
						fresh[k] = 1'b0;
					end else begin
						if (idle_count[k] != TMO_MAX)
							idle_count[k]++;
						if (idle_count[k] >= timeout_limit)
							wipe_channel(k);
					end
				end
			end
			CMD_CLEAR: begin
				for (int k = 0; k < NCH; k++)
					wipe_channel(k);
			end
			CMD_CAPTURE: begin
				if (it.chan < NCH) begin
					c = int'(it.chan);
					if (it.over && miss_count[c] != ERR_MAX)
						miss_count[c]++;
					if (it.cap_valid && !armed[c]) begin
						first_ts[c] = it.cap_value;
						armed[c]    = 1'b1;
					end else if (it.cap_valid) begin
						// equal stamps mean a whole counter wrap
						span = {1'b0, it.cap_value - first_ts[c]};
						if (span == '0)
							span = 17'h10000;
						per        = span * 10;
						r.chan_num = 2'(c + 1);
						r.err      = miss_count[c];
						r.period   = PERIOD_W'(per);
						r.pulse    = PULSE_W'(span * 5);
						r.freq     = FREQ_W'(32'd256000000 / per);
						expected_readings.push_back(r);
						idle_count[c] = '0;
						first_ts[c]   = '0;
						armed[c]      = 1'b0;
						fresh[c]      = 1'b1;
					end
				end
			end
			default: ;
		endcase
	endfunction

	function automatic meter_item_t make_item(cmd_t cmd, logic [1:0] chan, logic v,
			logic [15:0] ts, logic over);
		meter_item_t it;
		it.cmd       = cmd;
		it.chan      = chan;
		it.cap_valid = v;
		it.cap_value = ts;
		it.over      = over;
		return it;
	endfunction

	// Mostly capture pairs on live channels; some ticks, clears and junk
	function automatic meter_item_t random_item();
		meter_item_t it;
		int          pick;
		pick         = $urandom_range(0, 99);
		it.cmd       = CMD_CAPTURE;
		if (pick < 9)
			it.cmd = CMD_TICK;
		else if (pick < 11)
			it.cmd = CMD_CLEAR;
		else if (pick < 13)
			it.cmd = CMD_NONE;
		it.chan      = ($urandom_range(0, 29) == 0) ? 2'd3 : 2'($urandom_range(0, NCH - 1));
		it.cap_valid = $urandom_range(0, 9) != 0;
		it.over      = $urandom_range(0, 7) == 0;
		it.cap_value = 16'($urandom);
		if (it.chan < NCH && armed[it.chan]) begin
			case ($urandom_range(0, 5))
				0: it.cap_value = 16'(first_ts[it.chan] + $urandom_range(1, 4));
				1: it.cap_value = first_ts[it.chan];
				2: it.cap_value = first_ts[it.chan] - 16'd1;
				3: it.cap_value = 16'(first_ts[it.chan] + $urandom_range(0, 999));
				default: ;
			endcase
		end
		return it;
	endfunction

	// Drive one item and hold it until accepted. Bursts of random length,
	// random gaps in between when gaps_on is set.
	task automatic send_item(meter_item_t it);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if (gaps_on) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, it.over, it.cap_value, it.cap_valid, it.chan};
		s_tuser  <= it.cmd;
		do
			@(posedge clk);
		while (!s_tready);
		predict_reading(it);
	endtask

	// Drop valid, wait for every reading, then let tick walks finish
	task automatic drain_and_settle();
		s_tvalid   <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (expected_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Only called with the block idle
	task automatic set_timeout(logic [TMO_W-1:0] limit);
		cfg_we    <= 1'b1;
		cfg_wdata <= limit;
		@(posedge clk);
		cfg_we        <= 1'b0;
		timeout_limit = limit;
	endtask

	// Receiver: alternating ready runs and stalls of random length when stalls_on is set
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
		end else if (stalls_on && m_tready) begin
			stall_left = $urandom_range(0, 11);
			m_tready <= 1'b0;
		end else begin
			stall_left = $urandom_range(0, 23);
			m_tready <= 1'b1;
		end
	end

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	// Scoreboard: each reading against the oldest expectation
	always @(posedge clk) begin
		reading_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_readings.size() == 0) begin
				$error("unexpected reading, m_tdata=%h", m_tdata);
				mismatch_count++;
			end else begin
				want = expected_readings.pop_front();
				check_field("channel_number", 32'(want.chan_num), 32'(m_tdata[1:0]));
				check_field("err_count", 32'(want.err), 32'(m_tdata[17:2]));
				check_field("period_us", 32'(want.period), 32'(m_tdata[37:18]));
				check_field("pulse_width_us", 32'(want.pulse), 32'(m_tdata[56:38]));
				check_field("frequency_q8", 32'(want.freq), 32'(m_tdata[81:57]));
			end
		end
	end

	// Field extremes, wrap cases, ignored items, clear in mid-measurement
	task automatic test_directed_cases();
		gaps_on   = 1'b1;
		stalls_on = 1'b1;
		// near-full period, then a full wrap (the longest period) with errors, then the shortest period
		send_item(make_item(CMD_CAPTURE, 2'd0, 1'b1, 16'h0000, 1'b0));
		send_item(make_item(CMD_CAPTURE, 2'd0, 1'b1, 16'hFFFF, 1'b0));
		send_item(make_item(CMD_CAPTURE, 2'd1, 1'b1, 16'h1234, 1'b1));
		send_item(make_item(CMD_CAPTURE, 2'd1, 1'b1, 16'h1234, 1'b1));
		send_item(make_item(CMD_CAPTURE, 2'd2, 1'b1, 16'hFFFF, 1'b0));
		send_item(make_item(CMD_CAPTURE, 2'd2, 1'b1, 16'h0000, 1'b0));
		// out-of-range channel and the unused command are dropped
		send_item(make_item(CMD_CAPTURE, 2'd3, 1'b1, 16'h5555, 1'b1));
		send_item(make_item(CMD_NONE, 2'd0, 1'b1, 16'hAAAA, 1'b1));
		// no stamp, no error: nothing; error only: counted
		send_item(make_item(CMD_CAPTURE, 2'd0, 1'b0, 16'hFFFF, 1'b0));
		send_item(make_item(CMD_CAPTURE, 2'd0, 1'b0, 16'h0000, 1'b1));
		// clear drops the pending first stamp
		send_item(make_item(CMD_CAPTURE, 2'd0, 1'b1, 16'h8000, 1'b0));
		send_item(make_item(CMD_CLEAR, 2'd0, 1'b0, 16'h0000, 1'b0));
		send_item(make_item(CMD_CAPTURE, 2'd0, 1'b1, 16'h8001, 1'b0));
		send_item(make_item(CMD_CAPTURE, 2'd0, 1'b1, 16'h8003, 1'b1));
		send_item(make_item(CMD_TICK, 2'd0, 1'b0, 16'h0000, 1'b0));
		send_item(make_item(CMD_TICK, 2'd2, 1'b1, 16'hFFFF, 1'b1));
		send_item(make_item(CMD_CAPTURE, 2'd2, 1'b1, 16'h7FFF, 1'b0));
		send_item(make_item(CMD_CAPTURE, 2'd2, 1'b1, 16'h0001, 1'b0));
		drain_and_settle();
	endtask

	// Idle-channel resets at the limit extremes
	task automatic test_timeouts();
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		set_timeout(8'd1);
		send_item(make_item(CMD_CLEAR, 2'd0, 1'b0, 16'h0000, 1'b0));
		send_item(make_item(CMD_CAPTURE, 2'd0, 1'b1, 16'd100, 1'b0));
		send_item(make_item(CMD_TICK, 2'd0, 1'b0, 16'h0000, 1'b0));
		send_item(make_item(CMD_CAPTURE, 2'd0, 1'b1, 16'd200, 1'b0));
		send_item(make_item(CMD_CAPTURE, 2'd0, 1'b1, 16'd300, 1'b1));
		// error count goes with the timeout reset
		send_item(make_item(CMD_CAPTURE, 2'd1, 1'b0, 16'h0000, 1'b1));
		send_item(make_item(CMD_TICK, 2'd0, 1'b0, 16'h0000, 1'b0));
		send_item(make_item(CMD_CAPTURE, 2'd1, 1'b1, 16'd5, 1'b0));
		send_item(make_item(CMD_CAPTURE, 2'd1, 1'b1, 16'd10, 1'b0));
		drain_and_settle();

		// zero limit: every tick resets an idle channel
		set_timeout(8'd0);
		send_item(make_item(CMD_TICK, 2'd0, 1'b0, 16'h0000, 1'b0));
		send_item(make_item(CMD_CAPTURE, 2'd0, 1'b1, 16'd7, 1'b1));
		send_item(make_item(CMD_TICK, 2'd0, 1'b0, 16'h0000, 1'b0));
		send_item(make_item(CMD_CAPTURE, 2'd0, 1'b1, 16'd9, 1'b0));
		send_item(make_item(CMD_CAPTURE, 2'd0, 1'b1, 16'd19, 1'b0));
		drain_and_settle();

		// top limit: one tick short survives, the full count resets
		set_timeout(8'd255);
		stalls_on = 1'b1;
		send_item(make_item(CMD_CLEAR, 2'd0, 1'b0, 16'h0000, 1'b0));
		send_item(make_item(CMD_CAPTURE, 2'd2, 1'b1, 16'd1000, 1'b1));
		repeat (254) send_item(make_item(CMD_TICK, 2'd0, 1'b0, 16'h0000, 1'b0));
		send_item(make_item(CMD_CAPTURE, 2'd2, 1'b1, 16'd1500, 1'b0));
		send_item(make_item(CMD_CAPTURE, 2'd2, 1'b1, 16'd2000, 1'b1));
		repeat (256) send_item(make_item(CMD_TICK, 2'd0, 1'b0, 16'h0000, 1'b0));
		send_item(make_item(CMD_CAPTURE, 2'd2, 1'b1, 16'd3000, 1'b0));
		send_item(make_item(CMD_CAPTURE, 2'd2, 1'b1, 16'd3333, 1'b0));
		drain_and_settle();
	endtask

	// Random phases, each with its own limit and idling mix
	task automatic test_random_traffic();
		logic [TMO_W-1:0] limits [5];
		limits = '{8'd1, 8'd255, 8'd3, 8'd10, 8'd0};
		limits[3] = 8'($urandom_range(2, 254));
		for (int ph = 0; ph < 5; ph++) begin
			set_timeout(limits[ph]);
			gaps_on   = (ph == 1) || (ph >= 3);
			stalls_on = (ph >= 2);
			repeat (192) send_item(random_item());
			drain_and_settle();
		end
	endtask

	// Error counter over a long run of misses between two stamps
	task automatic test_error_count();
		gaps_on   = 1'b0;
		stalls_on = 1'b1;
		send_item(make_item(CMD_CLEAR, 2'd0, 1'b0, 16'h0000, 1'b0));
		send_item(make_item(CMD_CAPTURE, 2'd1, 1'b1, 16'h0100, 1'b0));
		repeat (40) send_item(make_item(CMD_CAPTURE, 2'd1, 1'b0, 16'($urandom), 1'b1));
		send_item(make_item(CMD_CAPTURE, 2'd1, 1'b1, 16'h0200, 1'b1));
		drain_and_settle();
	endtask

	initial begin
		for (int k = 0; k < NCH; k++)
			wipe_channel(k);
		timeout_limit = TIMEOUT_RST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_timeouts();
		test_random_traffic();
		test_error_count();
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: filelist.f
src/cfm_pkg.sv
src/capture_frequency_meter.sv
src/cfm_checker.sv
tb/capture_frequency_meter_tb.sv
